[rtl/core/mfpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mfpd_pkg;

    // Block sizing
    localparam int FADER_COUNT   = 8;
    localparam int POSITION_BITS = 10;
    localparam int ADDR_W        = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 3;
    localparam int POS_W   = 10;
    localparam int SCALE_W = 8;
    localparam int GAIN_W  = 8;
    localparam int CFG_IDX_W = 1;

    // (raw - lo) * 255 fits in POS_W + SCALE_W bits
    localparam int NUM_W = POS_W + SCALE_W;
    // kp*e + kd*(e - prev) spans -65025 .. 130050
    localparam int ACC_W = 18;

    localparam int FULL_SCALE = 255;

    // Mask applied to the raw reading
    localparam logic [POS_W-1:0] POS_MASK = POS_W'((64'd1 << POSITION_BITS) - 64'd1);

    // Commands
    localparam logic [CMD_W-1:0] CMD_CAP_TOP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CAP_BOT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd3;

    // Fader modes
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_INIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 1'd1;

endpackage

`default_nettype wire

[rtl/core/motor_fader_pd_drive_top.sv]
// An item passes through a setup step, the bit-serial divider, the bit-serial PD
// multiply-add and a write-back into the output register; no new item is taken
// until the previous one has been written back.
// A new item is taken while the previous result still waits in the output register.
// Reset (aresetn, synchronous, active low) sets both gains to 1 and clears all ends,
// previous errors and fader modes.
`timescale 1ns / 1ps
`default_nettype none

module motor_fader_pd_drive_top (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // configuration write port
    input  wire                                 cfg_wr_en,
    input  wire  [mfpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [mfpd_pkg::GAIN_W-1:0]         cfg_wr_data,
    // input items
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [mfpd_pkg::CMD_W-1:0]          s_command,
    input  wire  [mfpd_pkg::IDX_W-1:0]          s_fader_index,
    input  wire  [mfpd_pkg::POS_W-1:0]          s_raw_position,
    // result items
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [mfpd_pkg::IDX_W-1:0]          m_fader_number,
    output logic [mfpd_pkg::SCALE_W-1:0]        m_scaled_value,
    output logic                                m_drive_update,
    output logic [mfpd_pkg::SCALE_W-1:0]        m_duty,
    output logic                                m_positive_pin,
    output logic                                m_negative_pin,
    output logic                                m_auto_active,
    output logic                                m_calibration_bad
);

    localparam int POS_W   = mfpd_pkg::POS_W;
    localparam int SCALE_W = mfpd_pkg::SCALE_W;
    localparam int NUM_W   = mfpd_pkg::NUM_W;
    localparam int ACC_W   = mfpd_pkg::ACC_W;
    localparam int GAIN_W  = mfpd_pkg::GAIN_W;
    localparam int ADDR_W  = mfpd_pkg::ADDR_W;
    localparam int NF      = mfpd_pkg::FADER_COUNT;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    // Per-fader state
    logic [POS_W-1:0]            top_end_reg    [NF];
    logic [POS_W-1:0]            bottom_end_reg [NF];
    logic [SCALE_W-1:0]          prev_err_reg   [NF];
    logic [mfpd_pkg::MODE_W-1:0] mode_reg       [NF];

    logic [GAIN_W-1:0] gain_p_reg, gain_d_reg;

    // Item registers
    logic [mfpd_pkg::CMD_W-1:0] cmd_reg;
    logic [mfpd_pkg::IDX_W-1:0] idx_reg;
    logic [POS_W-1:0]           raw_reg;

    // Datapath registers
    logic                 bad_reg, bad_next;
    logic [POS_W-1:0]     den_reg, den_next;
    logic [POS_W-1:0]     rem_reg, rem_next;
    logic [SCALE_W-1:0]   nlo_reg, nlo_next;
    logic [SCALE_W-1:0]   q_reg, q_next;
    logic [SCALE_W-1:0]   err_reg, err_next;
    logic [SCALE_W-1:0]   prev_reg, prev_next;
    logic [ACC_W-1:0]     mp_reg, mp_next;
    logic [ACC_W-1:0]     md_reg, md_next;
    logic [GAIN_W-1:0]    kp_sr_reg, kp_sr_next;
    logic [GAIN_W-1:0]    kd_sr_reg, kd_sr_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;

    logic m_valid_reg, m_valid_next;

    logic [ADDR_W-1:0] addr;
    logic              in_range;
    logic              accept;
    logic              out_free;

    // setup-cycle values
    logic [POS_W-1:0]   top_eff, bot_eff, clamped, diff_pos;
    logic [NUM_W-1:0]   numer;
    // divider step
    logic [POS_W:0]     trial;
    logic               qbit;
    logic [SCALE_W-1:0] q_final;
    logic [SCALE_W:0]   err_diff;
    // finish
    logic               is_auto_tick, settled, drive, sum_pos;
    logic [ACC_W-1:0]   mag;
    logic [SCALE_W-1:0] duty_val;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign addr     = ADDR_W'(idx_reg);
    assign in_range = 32'(idx_reg) < 32'(NF);

    // Calibration ends as they stand after this item
    always_comb begin
        top_eff  = (cmd_reg == mfpd_pkg::CMD_CAP_TOP) ? raw_reg : top_end_reg[addr];
        bot_eff  = (cmd_reg == mfpd_pkg::CMD_CAP_BOT) ? raw_reg : bottom_end_reg[addr];
        if (raw_reg < bot_eff) begin
            clamped = bot_eff;
        end else if (raw_reg > top_eff) begin
            clamped = top_eff;
        end else begin
            clamped = raw_reg;
        end
        diff_pos = clamped - bot_eff;
        // d * 255 = (d << 8) - d
        numer    = {diff_pos, {SCALE_W{1'b0}}} - NUM_W'(diff_pos);
    end

    // Restoring divider step, one quotient bit per cycle
    always_comb begin
        trial   = {rem_reg, nlo_reg[SCALE_W-1]};
        qbit    = trial >= {1'b0, den_reg};
        q_final = {q_reg[SCALE_W-2:0], qbit};
        err_diff = {1'b0, (bad_reg ? {SCALE_W{1'b0}} : q_final)} - {1'b0, prev_reg};
    end

    // PD result decode
    always_comb begin
        is_auto_tick = in_range && (cmd_reg == mfpd_pkg::CMD_TICK)
                       && (mode_reg[addr] == mfpd_pkg::MODE_AUTO);
        settled  = (err_reg == '0) && (prev_reg == '0);
        drive    = is_auto_tick && !settled;
        sum_pos  = !acc_reg[ACC_W-1] && (acc_reg != '0);
        mag      = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
        duty_val = (mag > ACC_W'(mfpd_pkg::FULL_SCALE)) ?
                   SCALE_W'(mfpd_pkg::FULL_SCALE) : mag[SCALE_W-1:0];
    end

    // Sequencer and datapath next state
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        bad_next     = bad_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        nlo_next     = nlo_reg;
        q_next       = q_reg;
        err_next     = err_reg;
        prev_next    = prev_reg;
        mp_next      = mp_reg;
        md_next      = md_reg;
        kp_sr_next   = kp_sr_reg;
        kd_sr_next   = kd_sr_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                bad_next   = top_eff <= bot_eff;
                den_next   = top_eff - bot_eff;
                rem_next   = numer[NUM_W-1:SCALE_W];
                nlo_next   = numer[SCALE_W-1:0];
                q_next     = '0;
                prev_next  = prev_err_reg[addr];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = qbit ? POS_W'(trial - {1'b0, den_reg}) : trial[POS_W-1:0];
                nlo_next = {nlo_reg[SCALE_W-2:0], 1'b0};
                q_next   = q_final;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    err_next   = bad_reg ? '0 : q_final;
                    mp_next    = ACC_W'(bad_reg ? {SCALE_W{1'b0}} : q_final);
                    md_next    = {{(ACC_W-SCALE_W-1){err_diff[SCALE_W]}}, err_diff};
                    kp_sr_next = gain_p_reg;
                    kd_sr_next = gain_d_reg;
                    acc_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // one gain bit per cycle for both terms
                acc_next   = acc_reg + (kp_sr_reg[0] ? mp_reg : '0)
                                     + (kd_sr_reg[0] ? md_reg : '0);
                mp_next    = {mp_reg[ACC_W-2:0], 1'b0};
                md_next    = {md_reg[ACC_W-2:0], 1'b0};
                kp_sr_next = {1'b0, kp_sr_reg[GAIN_W-1:1]};
                kd_sr_next = {1'b0, kd_sr_reg[GAIN_W-1:1]};
                cnt_next   = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and per-fader state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            gain_p_reg  <= GAIN_W'(1);
            gain_d_reg  <= GAIN_W'(1);
            for (int i = 0; i < NF; i++) begin
                top_end_reg[i]    <= '0;
                bottom_end_reg[i] <= '0;
                prev_err_reg[i]   <= '0;
                mode_reg[i]       <= mfpd_pkg::MODE_INIT;
            end
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en && cfg_index == mfpd_pkg::REG_GAIN_P) begin
                gain_p_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_index == mfpd_pkg::REG_GAIN_D) begin
                gain_d_reg <= cfg_wr_data;
            end
            // captures and start take effect in the setup cycle
            if (state_reg == ST_SETUP && in_range) begin
                case (cmd_reg)
                    mfpd_pkg::CMD_CAP_TOP: begin
                        top_end_reg[addr] <= raw_reg;
                    end
                    mfpd_pkg::CMD_CAP_BOT: begin
                        bottom_end_reg[addr] <= raw_reg;
                        mode_reg[addr]       <= mfpd_pkg::MODE_MANUAL;
                    end
                    mfpd_pkg::CMD_START: begin
                        mode_reg[addr] <= mfpd_pkg::MODE_AUTO;
                    end
                    default: begin
                    end
                endcase
            end
            // settle or record the error when the result goes out
            if (state_reg == ST_DONE && out_free && is_auto_tick) begin
                if (settled) begin
                    mode_reg[addr] <= mfpd_pkg::MODE_MANUAL;
                end else begin
                    prev_err_reg[addr] <= err_reg;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_command;
            idx_reg <= s_fader_index;
            raw_reg <= s_raw_position & mfpd_pkg::POS_MASK;
        end
        bad_reg   <= bad_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        nlo_reg   <= nlo_next;
        q_reg     <= q_next;
        err_reg   <= err_next;
        prev_reg  <= prev_next;
        mp_reg    <= mp_next;
        md_reg    <= md_next;
        kp_sr_reg <= kp_sr_next;
        kd_sr_reg <= kd_sr_next;
        acc_reg   <= acc_next;
        if (state_reg == ST_DONE && out_free) begin
            m_fader_number    <= idx_reg;
            m_scaled_value    <= in_range ? err_reg : '0;
            m_calibration_bad <= in_range && bad_reg;
            m_drive_update    <= drive;
            m_duty            <= drive ? duty_val : '0;
            m_positive_pin    <= drive && !sum_pos;
            m_negative_pin    <= drive && sum_pos;
            m_auto_active     <= is_auto_tick ? !settled :
                                 (in_range && mode_reg[addr] == mfpd_pkg::MODE_AUTO);
        end
    end

`ifndef ASSERT_OFF
    // a driven result sets exactly one bridge pin
    a_one_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drive_update) |-> (m_positive_pin ^ m_negative_pin))
        else $error("drive result without exactly one pin");

    // no drive means zero duty and both pins low
    a_no_drive_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_drive_update) |->
        (m_duty == '0 && !m_positive_pin && !m_negative_pin))
        else $error("duty or pins set without drive");

    // bad calibration reports zero position
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_calibration_bad) |-> (m_scaled_value == '0))
        else $error("bad calibration with nonzero position");

    // drive only while the fader stays in auto mode
    a_drive_auto: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drive_update) |-> m_auto_active)
        else $error("drive outside auto mode");

    // setup always starts the divider at its first step
    a_setup_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SETUP) |=> (state_reg == ST_DIV && cnt_reg == 3'd0))
        else $error("divider did not start after setup");
`endif

endmodule

`default_nettype wire
